// File: rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// shared types, widths, row codes and saturation helper for the look-at unit
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int COORD_W        = 32;
    localparam int LAVM_FRAC_BITS = 16;
    localparam int MATRIX_SIZE    = 4;
    localparam int ROW_W          = $clog2(MATRIX_SIZE);

    // difference and magnitude widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int NORM_W = COORD_W - 1;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = 64;

    // square root and divider unrolling
    localparam int ROOT_W       = 32;
    localparam int SQRT_REM_W   = ROOT_W + 4;
    localparam int SQRT_STEPS   = 4;
    localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;
    localparam int DIV_STEPS    = 4;

    localparam int PROD_W   = 2 * COORD_W;
    localparam int SAT_IN_W = PROD_W + 4;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SAT_IN_W-1:0] wide_t;

    // row codes
    localparam logic [ROW_W-1:0] ROW_LEFT = ROW_W'(0);
    localparam logic [ROW_W-1:0] ROW_UP   = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_BACK = ROW_W'(2);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MATRIX_SIZE - 1);

    // axis rotation for cross products
    localparam int NEXT_AX [3] = '{1, 2, 0};
    localparam int PREV_AX [3] = '{2, 0, 1};

    function automatic coord_t sat_coord(input wide_t v);
        coord_t res;
        if (v[SAT_IN_W-1:COORD_W-1] == '0 || v[SAT_IN_W-1:COORD_W-1] == '1)
        begin
            res = coord_t'(v[COORD_W-1:0]);
        end
        else if (v[SAT_IN_W-1])
        begin
            res = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
        end
        else
        begin
            res = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
        end
        return res;
    endfunction

endpackage

// File: rtl/lavm_req_if.sv
// ----------------------------------------------------------------------------
// lavm_req_if
// request channel: eye point, target point and up direction
// ----------------------------------------------------------------------------
interface lavm_req_if
    import lavm_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
    coord_t up_x;
    coord_t up_y;
    coord_t up_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        input  ready
    );

    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z,
        output ready
    );
endinterface

// File: rtl/lavm_res_if.sv
// ----------------------------------------------------------------------------
// lavm_res_if
// result channel: one view matrix row per transfer
// ----------------------------------------------------------------------------
interface lavm_res_if
    import lavm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;
    coord_t           col0;
    coord_t           col1;
    coord_t           col2;
    coord_t           col3;
    logic             degenerate;
    logic             last_row;

    modport source (
        output valid, row_index, col0, col1, col2, col3, degenerate, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_index, col0, col1, col2, col3, degenerate, last_row,
        output ready
    );
endinterface

// File: rtl/lavm_norm.sv
// ----------------------------------------------------------------------------
// lavm_norm
// pipelined vector normaliser: range shift, sum of squares, digit square
// root and restoring division, four steps per stage
// ----------------------------------------------------------------------------
module lavm_norm
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = LAVM_FRAC_BITS
)
(
    input  logic   clk,
    input  logic   en,
    input  diff_t  vec  [3],
    output coord_t unit [3],
    output logic   zero
);

    localparam int QW         = FRAC_BITS + 1;
    localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_REM_W  = ROOT_W + 1;
    localparam int LEAD_W     = $clog2(DIFF_W);

    typedef logic [DIFF_W-1:0] mag_t;
    typedef logic [NORM_W-1:0] nmag_t;

    typedef struct packed {
        nmag_t [2:0] nm;
        logic  [2:0] sgn;
        logic        zero;
    } side_t;

    typedef struct packed {
        logic [SQRT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
    } sqrt_t;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [QW-1:0]        q;
    } quo_t;

    typedef quo_t [2:0] quo3_t;

    function automatic sqrt_t sqrt_stage(input sqrt_t s, input logic [SUM_W-1:0] x,
                                         input int first);
        sqrt_t                 o;
        logic [SQRT_REM_W-1:0] r;
        logic [SQRT_REM_W-1:0] t;
        o = s;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            r = {o.rem[SQRT_REM_W-3:0], x[SUM_W-1-2*(first+k) -: 2]};
            t = {{(SQRT_REM_W-ROOT_W-2){1'b0}}, o.root, 2'b01};
            if (r >= t)
            begin
                o.rem  = r - t;
                o.root = {o.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                o.rem  = r;
                o.root = {o.root[ROOT_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    function automatic quo_t div_stage(input quo_t s, input logic [ROOT_W-1:0] len,
                                       input logic lsb, input int first);
        quo_t                 o;
        logic [DIV_REM_W-1:0] r;
        o = s;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (first + k < QW)
            begin
                r = {o.rem[DIV_REM_W-2:0], (first + k == 0) ? lsb : 1'b0};
                if (r >= {1'b0, len})
                begin
                    o.rem = r - {1'b0, len};
                    o.q   = {o.q[QW-2:0], 1'b1};
                end
                else
                begin
                    o.rem = r;
                    o.q   = {o.q[QW-2:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

    mag_t              mag_reg [3];
    logic [2:0]        sgn_reg;
    side_t             side_b_reg;
    side_t             side_b_next;
    logic [SQ_W-1:0]   sq_reg [3];
    side_t             side_c_reg;
    logic [SUM_W-1:0]  sum_reg;
    side_t             side_d_reg;
    sqrt_t             sqrt_reg  [SQRT_STAGES];
    sqrt_t             sqrt_next [SQRT_STAGES];
    logic [SUM_W-1:0]  x_reg     [SQRT_STAGES];
    side_t             sside_reg [SQRT_STAGES];
    quo3_t             div_reg   [DIV_STAGES];
    quo3_t             div_next  [DIV_STAGES];
    logic [ROOT_W-1:0] len_reg   [DIV_STAGES];
    side_t             dside_reg [DIV_STAGES];
    coord_t            unit_reg  [3];
    coord_t            unit_next [3];
    logic              zero_reg;

    // range shift so the largest magnitude lands in [2^30, 2^31)
    always_comb
    begin
        mag_t              orw;
        logic [LEAD_W-1:0] lead;
        orw  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        lead = '0;
        for (int i = 0; i < DIFF_W; i++)
        begin
            if (orw[i])
            begin
                lead = LEAD_W'(i);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (lead >= LEAD_W'(NORM_W - 1))
            begin
                side_b_next.nm[k] = NORM_W'(mag_reg[k] >> (lead - LEAD_W'(NORM_W - 1)));
            end
            else
            begin
                side_b_next.nm[k] = NORM_W'(mag_reg[k] << (LEAD_W'(NORM_W - 1) - lead));
            end
        end
        side_b_next.sgn  = sgn_reg;
        side_b_next.zero = (orw == '0);
    end

    // square root chain
    always_comb
    begin
        sqrt_next[0] = sqrt_stage('0, sum_reg, 0);
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            sqrt_next[s] = sqrt_stage(sqrt_reg[s-1], x_reg[s-1], s * SQRT_STEPS);
        end
    end

    // divider chain, quotient below 2^(FRAC_BITS+1) since len >= 2^30
    always_comb
    begin
        quo_t init;
        init = '0;
        for (int c = 0; c < 3; c++)
        begin
            init.rem       = DIV_REM_W'(sside_reg[SQRT_STAGES-1].nm[c] >> 1);
            init.q         = '0;
            div_next[0][c] = div_stage(init, sqrt_reg[SQRT_STAGES-1].root,
                                       sside_reg[SQRT_STAGES-1].nm[c][0], 0);
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                div_next[j][c] = div_stage(div_reg[j-1][c], len_reg[j-1],
                                           dside_reg[j-1].nm[c][0], j * DIV_STEPS);
            end
        end
    end

    // sign restore, zero vector gives zero components
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (dside_reg[DIV_STAGES-1].zero)
            begin
                unit_next[c] = '0;
            end
            else if (dside_reg[DIV_STAGES-1].sgn[c])
            begin
                unit_next[c] = -coord_t'(COORD_W'(div_reg[DIV_STAGES-1][c].q));
            end
            else
            begin
                unit_next[c] = coord_t'(COORD_W'(div_reg[DIV_STAGES-1][c].q));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= vec[k][DIFF_W-1] ? mag_t'(-vec[k]) : mag_t'(vec[k]);
                sgn_reg[k] <= vec[k][DIFF_W-1];
                sq_reg[k]  <= SQ_W'(side_b_reg.nm[k]) * SQ_W'(side_b_reg.nm[k]);
            end
            side_b_reg <= side_b_next;
            side_c_reg <= side_b_reg;
            sum_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            side_d_reg <= side_c_reg;

            sqrt_reg[0]  <= sqrt_next[0];
            x_reg[0]     <= sum_reg;
            sside_reg[0] <= side_d_reg;
            for (int s = 1; s < SQRT_STAGES; s++)
            begin
                sqrt_reg[s]  <= sqrt_next[s];
                x_reg[s]     <= x_reg[s-1];
                sside_reg[s] <= sside_reg[s-1];
            end

            div_reg[0]   <= div_next[0];
            len_reg[0]   <= sqrt_reg[SQRT_STAGES-1].root;
            dside_reg[0] <= sside_reg[SQRT_STAGES-1];
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                div_reg[j]   <= div_next[j];
                len_reg[j]   <= len_reg[j-1];
                dside_reg[j] <= dside_reg[j-1];
            end

            unit_reg <= unit_next;
            zero_reg <= dside_reg[DIV_STAGES-1].zero;
        end
    end

    assign unit = unit_reg;
    assign zero = zero_reg;

endmodule

// File: rtl/look_at_view_matrix_unit.sv
// rows 0 to 3 leave on consecutive cycles while the result side is ready
// the four rows of a matrix share one result port, and the serialiser holds one matrix at a time;
// the pipeline itself takes a request every cycle until the row serialiser is full
// reset clears the stage valid bits, the serialiser busy flag and its row counter
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// builds the 4x4 look-at view matrix from eye, target and up, one row per result
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = LAVM_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    lavm_req_if.sink   request,
    lavm_res_if.source result
);

    // normaliser depth: range shift, squares, sum, root, divide, sign
    localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS) / DIV_STEPS;
    localparam int NORM_LAT   = 5 + SQRT_STAGES + DIV_STAGES;
    // capture stage, normaliser, six cross and dot product stages
    localparam int PIPE_DEPTH = 1 + NORM_LAT + 6;

    function automatic prod_t mul(input coord_t a, input coord_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    // floored difference of products, saturated
    function automatic coord_t cross_fin(input prod_t pa, input prod_t pb);
        wide_t w;
        w = (wide_t'(pa) - wide_t'(pb)) >>> FRAC_BITS;
        return sat_coord(w);
    endfunction

    // negated floored dot product, saturated
    function automatic coord_t trans_fin(input prod_t p0, input prod_t p1, input prod_t p2);
        wide_t w;
        w = (wide_t'(p0) + wide_t'(p1) + wide_t'(p2)) >>> FRAC_BITS;
        return sat_coord(-w);
    endfunction

    logic                   en;
    logic [PIPE_DEPTH-1:0]  v_reg;

    // capture stage
    coord_t eye_reg [3];
    diff_t  d_reg   [3];
    diff_t  u_reg   [3];
    coord_t eye_dly_reg [NORM_LAT][3];

    // normaliser outputs
    coord_t fwd [3];
    coord_t upn [3];
    logic   fwd_zero;
    logic   upn_zero;

    // c1: left products
    prod_t  c1_p_reg   [6];
    prod_t  c1_p_next  [6];
    coord_t c1_fwd_reg [3];
    coord_t c1_eye_reg [3];
    logic   c1_deg_reg;

    // c2: left and back vectors
    coord_t c2_left_reg [3];
    coord_t c2_left_next[3];
    coord_t c2_nf_reg   [3];
    coord_t c2_nf_next  [3];
    coord_t c2_fwd_reg  [3];
    coord_t c2_eye_reg  [3];
    logic   c2_deg_reg;

    // c3: true up products and translation products for left and back rows
    prod_t  c3_pc_reg   [6];
    prod_t  c3_pc_next  [6];
    prod_t  c3_pl_reg   [3];
    prod_t  c3_pl_next  [3];
    prod_t  c3_pn_reg   [3];
    prod_t  c3_pn_next  [3];
    coord_t c3_left_reg [3];
    coord_t c3_nf_reg   [3];
    coord_t c3_eye_reg  [3];
    logic   c3_deg_reg;

    // c4: true up, translation of left and back rows
    coord_t c4_tup_reg  [3];
    coord_t c4_tup_next [3];
    coord_t c4_t0_reg;
    coord_t c4_t0_next;
    coord_t c4_t2_reg;
    coord_t c4_t2_next;
    coord_t c4_left_reg [3];
    coord_t c4_nf_reg   [3];
    coord_t c4_eye_reg  [3];
    logic   c4_deg_reg;

    // c5: translation products for the true up row
    prod_t  c5_pt_reg   [3];
    prod_t  c5_pt_next  [3];
    coord_t c5_left_reg [3];
    coord_t c5_nf_reg   [3];
    coord_t c5_tup_reg  [3];
    coord_t c5_t0_reg;
    coord_t c5_t2_reg;
    logic   c5_deg_reg;

    // c6: last translation term
    coord_t c6_t1_reg;
    coord_t c6_t1_next;
    coord_t c6_left_reg [3];
    coord_t c6_nf_reg   [3];
    coord_t c6_tup_reg  [3];
    coord_t c6_t0_reg;
    coord_t c6_t2_reg;
    logic   c6_deg_reg;

    // row serialiser
    logic             sr_busy_reg;
    logic [ROW_W-1:0] sr_row_reg;
    coord_t           sr_left_reg [3];
    coord_t           sr_tup_reg  [3];
    coord_t           sr_nf_reg   [3];
    coord_t           sr_t0_reg;
    coord_t           sr_t1_reg;
    coord_t           sr_t2_reg;
    logic             sr_deg_reg;

    // whole pipeline advances unless a finished matrix waits at the serialiser
    assign en            = !sr_busy_reg || (result.ready && sr_row_reg == ROW_LAST);
    assign request.ready = en;

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_fwd (
        .clk  (clk),
        .en   (en),
        .vec  (d_reg),
        .unit (fwd),
        .zero (fwd_zero)
    );

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_up (
        .clk  (clk),
        .en   (en),
        .vec  (u_reg),
        .unit (upn),
        .zero (upn_zero)
    );

    // valid bits travel alongside the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], request.valid};
        end
    end

    // cross and dot product datapath
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // left = fwd x upn
            c1_p_next[2*i]   = mul(fwd[NEXT_AX[i]], upn[PREV_AX[i]]);
            c1_p_next[2*i+1] = mul(fwd[PREV_AX[i]], upn[NEXT_AX[i]]);
            c2_left_next[i]  = cross_fin(c1_p_reg[2*i], c1_p_reg[2*i+1]);
            c2_nf_next[i]    = -c1_fwd_reg[i];
            // true up = left x fwd
            c3_pc_next[2*i]   = mul(c2_left_reg[NEXT_AX[i]], c2_fwd_reg[PREV_AX[i]]);
            c3_pc_next[2*i+1] = mul(c2_left_reg[PREV_AX[i]], c2_fwd_reg[NEXT_AX[i]]);
            c3_pl_next[i]     = mul(c2_left_reg[i], c2_eye_reg[i]);
            c3_pn_next[i]     = mul(c2_nf_reg[i], c2_eye_reg[i]);
            c4_tup_next[i]    = cross_fin(c3_pc_reg[2*i], c3_pc_reg[2*i+1]);
            c5_pt_next[i]     = mul(c4_tup_reg[i], c4_eye_reg[i]);
        end
        c4_t0_next = trans_fin(c3_pl_reg[0], c3_pl_reg[1], c3_pl_reg[2]);
        c4_t2_next = trans_fin(c3_pn_reg[0], c3_pn_reg[1], c3_pn_reg[2]);
        c6_t1_next = trans_fin(c5_pt_reg[0], c5_pt_reg[1], c5_pt_reg[2]);
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eye_reg[0] <= request.eye_x;
            eye_reg[1] <= request.eye_y;
            eye_reg[2] <= request.eye_z;
            d_reg[0]   <= diff_t'(request.target_x) - diff_t'(request.eye_x);
            d_reg[1]   <= diff_t'(request.target_y) - diff_t'(request.eye_y);
            d_reg[2]   <= diff_t'(request.target_z) - diff_t'(request.eye_z);
            u_reg[0]   <= diff_t'(request.up_x);
            u_reg[1]   <= diff_t'(request.up_y);
            u_reg[2]   <= diff_t'(request.up_z);

            eye_dly_reg[0] <= eye_reg;
            for (int k = 1; k < NORM_LAT; k++)
            begin
                eye_dly_reg[k] <= eye_dly_reg[k-1];
            end

            c1_p_reg   <= c1_p_next;
            c1_fwd_reg <= fwd;
            c1_eye_reg <= eye_dly_reg[NORM_LAT-1];
            c1_deg_reg <= fwd_zero | upn_zero;

            c2_left_reg <= c2_left_next;
            c2_nf_reg   <= c2_nf_next;
            c2_fwd_reg  <= c1_fwd_reg;
            c2_eye_reg  <= c1_eye_reg;
            c2_deg_reg  <= c1_deg_reg;

            c3_pc_reg   <= c3_pc_next;
            c3_pl_reg   <= c3_pl_next;
            c3_pn_reg   <= c3_pn_next;
            c3_left_reg <= c2_left_reg;
            c3_nf_reg   <= c2_nf_reg;
            c3_eye_reg  <= c2_eye_reg;
            c3_deg_reg  <= c2_deg_reg;

            c4_tup_reg  <= c4_tup_next;
            c4_t0_reg   <= c4_t0_next;
            c4_t2_reg   <= c4_t2_next;
            c4_left_reg <= c3_left_reg;
            c4_nf_reg   <= c3_nf_reg;
            c4_eye_reg  <= c3_eye_reg;
            c4_deg_reg  <= c3_deg_reg;

            c5_pt_reg   <= c5_pt_next;
            c5_left_reg <= c4_left_reg;
            c5_nf_reg   <= c4_nf_reg;
            c5_tup_reg  <= c4_tup_reg;
            c5_t0_reg   <= c4_t0_reg;
            c5_t2_reg   <= c4_t2_reg;
            c5_deg_reg  <= c4_deg_reg;

            c6_t1_reg   <= c6_t1_next;
            c6_left_reg <= c5_left_reg;
            c6_nf_reg   <= c5_nf_reg;
            c6_tup_reg  <= c5_tup_reg;
            c6_t0_reg   <= c5_t0_reg;
            c6_t2_reg   <= c5_t2_reg;
            c6_deg_reg  <= c5_deg_reg;

            // serialiser payload, only meaningful when the last stage was valid
            sr_left_reg <= c6_left_reg;
            sr_tup_reg  <= c6_tup_reg;
            sr_nf_reg   <= c6_nf_reg;
            sr_t0_reg   <= c6_t0_reg;
            sr_t1_reg   <= c6_t1_reg;
            sr_t2_reg   <= c6_t2_reg;
            sr_deg_reg  <= c6_deg_reg;
        end
    end

    // serialiser control: load on advance, step one row per accepted result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_busy_reg <= 1'b0;
            sr_row_reg  <= ROW_LEFT;
        end
        else if (en)
        begin
            sr_busy_reg <= v_reg[PIPE_DEPTH-1];
            sr_row_reg  <= ROW_LEFT;
        end
        else if (result.ready)
        begin
            sr_row_reg <= sr_row_reg + ROW_W'(1);
        end
    end

    assign result.valid      = sr_busy_reg;
    assign result.row_index  = sr_row_reg;
    assign result.degenerate = sr_deg_reg;
    assign result.last_row   = (sr_row_reg == ROW_LAST);

    // row select
    always_comb
    begin
        case (sr_row_reg)
            ROW_LEFT:
            begin
                result.col0 = sr_left_reg[0];
                result.col1 = sr_left_reg[1];
                result.col2 = sr_left_reg[2];
                result.col3 = sr_t0_reg;
            end
            ROW_UP:
            begin
                result.col0 = sr_tup_reg[0];
                result.col1 = sr_tup_reg[1];
                result.col2 = sr_tup_reg[2];
                result.col3 = sr_t1_reg;
            end
            ROW_BACK:
            begin
                result.col0 = sr_nf_reg[0];
                result.col1 = sr_nf_reg[1];
                result.col2 = sr_nf_reg[2];
                result.col3 = sr_t2_reg;
            end
            default:
            begin
                // homogeneous row: 0 0 0 1.0
                result.col0 = '0;
                result.col1 = '0;
                result.col2 = '0;
                result.col3 = coord_t'(COORD_W'(1) << FRAC_BITS);
            end
        endcase
    end

endmodule

// File: rtl/lavm_checker.sv
// ----------------------------------------------------------------------------
// lavm_checker
// port-level checks on the row stream of the look-at unit
// ----------------------------------------------------------------------------
module lavm_checker
    import lavm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic [ROW_W-1:0] row_index,
    input coord_t           col0,
    input coord_t           col1,
    input coord_t           col2,
    input coord_t           col3,
    input logic             degenerate,
    input logic             last_row
);

    // stalled row holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(row_index) && $stable(col0)
            && $stable(col1) && $stable(col2) && $stable(col3) && $stable(degenerate))
        else $error("stalled row changed");

    // rows of one matrix follow without a gap, in order
    a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last_row |=>
            res_valid && row_index == ROW_W'($past(row_index) + ROW_W'(1)))
        else $error("row sequence broken");

    // a new matrix starts at row 0
    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && last_row |=> !res_valid || row_index == ROW_LEFT)
        else $error("matrix did not start at row 0");

    // degenerate flag constant over one matrix
    a_deg_same: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last_row |=> degenerate == $past(degenerate))
        else $error("degenerate flag changed within a matrix");

    // last row carries the last row index and zeros in columns 0 to 2
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_row |-> row_index == ROW_LAST && col0 == '0 && col1 == '0
            && col2 == '0)
        else $error("last row not homogeneous");

endmodule

bind look_at_view_matrix_unit lavm_checker u_lavm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .row_index  (result.row_index),
    .col0       (result.col0),
    .col1       (result.col1),
    .col2       (result.col2),
    .col3       (result.col3),
    .degenerate (result.degenerate),
    .last_row   (result.last_row)
);

// File: dv/look_at_view_matrix_unit_checker.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit_checker
// predicts the four view matrix rows of every accepted request and compares
// them field by field with the rows leaving the result channel
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit_checker
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = LAVM_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    lavm_req_if        request,
    lavm_res_if        result,
    output int         fail_count,
    output int         rows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        coord_t           col0;
        coord_t           col1;
        coord_t           col2;
        coord_t           col3;
        logic             degenerate;
        logic             last_row;
    } view_row_t;

    view_row_t row_queue[$];

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    function automatic longint clamp32(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // arithmetic shift floors towards minus infinity
    function automatic longint floor_frac(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector scaled to FRAC_BITS, returns 1 for a zero vector
    function automatic bit unit_vec(input longint d[3], output longint n[3]);
        longint unsigned m[3];
        longint unsigned top;
        longint unsigned acc;
        longint unsigned len;
        top = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = d[i] < 0 ? -d[i] : d[i];
            if (m[i] > top) top = m[i];
        end
        if (top == 0)
        begin
            n = '{0, 0, 0};
            return 1'b1;
        end
        while (top >= 64'h8000_0000)
        begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < 64'h4000_0000)
        begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + m[i] * m[i];
        len = int_sqrt(acc);
        for (int i = 0; i < 3; i++)
        begin
            n[i] = longint'((m[i] << FRAC_BITS) / len);
            if (d[i] < 0) n[i] = -n[i];
        end
        return 1'b0;
    endfunction

    function automatic void cross_fx(input longint a[3], input longint b[3],
                                     output longint c[3]);
        c[0] = clamp32(floor_frac(a[1] * b[2] - a[2] * b[1]));
        c[1] = clamp32(floor_frac(a[2] * b[0] - a[0] * b[2]));
        c[2] = clamp32(floor_frac(a[0] * b[1] - a[1] * b[0]));
    endfunction

    // -(row . eye) floored; 128-bit sum is exact
    function automatic longint translation(input longint r[3], input longint e[3]);
        logic signed [127:0] s;
        s = 0;
        for (int i = 0; i < 3; i++) s = s + 128'(r[i]) * 128'(e[i]);
        s = -(s >>> FRAC_BITS);
        if (s > 128'(COORD_MAX)) return COORD_MAX;
        if (s < 128'(COORD_MIN)) return COORD_MIN;
        return longint'(s);
    endfunction

    task automatic predict_view_rows();
        longint eye[3], d[3], u[3], fwd[3], upn[3], lft[3], tup[3], back[3];
        longint rows[4][4];
        bit degen;
        view_row_t r;
        eye = '{request.eye_x, request.eye_y, request.eye_z};
        d = '{longint'(request.target_x) - eye[0], longint'(request.target_y) - eye[1],
              longint'(request.target_z) - eye[2]};
        u = '{request.up_x, request.up_y, request.up_z};
        degen = unit_vec(d, fwd);
        degen = unit_vec(u, upn) | degen;
        cross_fx(fwd, upn, lft);
        cross_fx(lft, fwd, tup);
        for (int i = 0; i < 3; i++)
        begin
            back[i] = -fwd[i];
            rows[0][i] = lft[i];
            rows[1][i] = tup[i];
            rows[2][i] = back[i];
            rows[3][i] = 0;
        end
        rows[0][3] = translation(lft, eye);
        rows[1][3] = translation(tup, eye);
        rows[2][3] = translation(back, eye);
        rows[3][3] = 64'sd1 << FRAC_BITS;
        for (int k = 0; k < MATRIX_SIZE; k++)
        begin
            r.row_index  = ROW_W'(k);
            r.col0       = coord_t'(rows[k][0]);
            r.col1       = coord_t'(rows[k][1]);
            r.col2       = coord_t'(rows[k][2]);
            r.col3       = coord_t'(rows[k][3]);
            r.degenerate = degen;
            r.last_row   = (ROW_W'(k) == ROW_LAST);
            row_queue.push_back(r);
        end
    endtask

    task automatic compare_row();
        view_row_t want;
        view_row_t got;
        got = '{result.row_index, result.col0, result.col1, result.col2, result.col3,
                result.degenerate, result.last_row};
        if (row_queue.size() == 0)
        begin
            $display("%0t: unexpected row %p", $time, got);
            fail_count++;
        end
        else
        begin
            want = row_queue.pop_front();
            if (want !== got)
            begin
                $display("%0t: row mismatch expected %p actual %p", $time, want, got);
                fail_count++;
            end
        end
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready) compare_row();
            if (request.valid && request.ready) predict_view_rows();
        end
        rows_pending <= row_queue.size();
    end

    initial rows_pending = 0;
endmodule

// File: dv/look_at_view_matrix_unit_tb.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit_tb
// drives camera requests with random gaps and result stalls; the checker
// predicts every matrix row and counts mismatches
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit_tb;
    import lavm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 280;
    localparam int N_PRESSURE = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   rows_pending;
    int   cycle_count;
    bit   stall_long;   // set by the stimulus to ask for a long result hold-off

    lavm_req_if request();
    lavm_res_if result();

    look_at_view_matrix_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    look_at_view_matrix_unit_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .result       (result),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // coordinate picks: extremes, small values and full random
    function automatic coord_t pick_coord();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return coord_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_request(input coord_t v[9]);
        request.eye_x    <= v[0];
        request.eye_y    <= v[1];
        request.eye_z    <= v[2];
        request.target_x <= v[3];
        request.target_y <= v[4];
        request.target_z <= v[5];
        request.up_x     <= v[6];
        request.up_y     <= v[7];
        request.up_z     <= v[8];
        request.valid    <= 1'b1;
        @(posedge clk);
        while (!request.ready) @(posedge clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            request.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic random_request();
        coord_t v[9];
        int p;
        foreach (v[i]) v[i] = pick_coord();
        p = $urandom_range(0, 19);
        // target on the eye, zero up, or up along the view direction
        if (p == 0) v[3:5] = v[0:2];
        if (p == 1) v[6:8] = '{0, 0, 0};
        if (p == 2)
        begin
            v[6] = v[3] - v[0];
            v[7] = v[4] - v[1];
            v[8] = v[5] - v[2];
        end
        send_request(v);
    endtask

    // result side ready: random stalls, a long hold-off on request
    initial
    begin
        int n;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_long)
            begin
                result.ready <= 1'b0;
                repeat (300) @(posedge clk);
                stall_long = 1'b0;
            end
            n = gap_len();
            if (n > 0)
            begin
                result.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            result.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // timeout watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("look_at_view_matrix_unit_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        coord_t v[9];
        stall_long = 1'b0;
        request.valid    = 1'b0;
        request.eye_x    = 0;
        request.eye_y    = 0;
        request.eye_z    = 0;
        request.target_x = 0;
        request.target_y = 0;
        request.target_z = 0;
        request.up_x     = 0;
        request.up_y     = 0;
        request.up_z     = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: plain camera, degenerate cases, parallel up, extremes
        v = '{0, 0, 32'sh0005_0000, 0, 0, 0, 0, 32'sh0001_0000, 0};
        send_request(v);
        v = '{32'sh0001_0000, 2, 3, 32'sh0001_0000, 2, 3, 0, 32'sh0001_0000, 0};
        send_request(v);
        v = '{1, 2, 3, 7, 8, 9, 0, 0, 0};
        send_request(v);
        v = '{5, 5, 5, 5, 5, 5, 0, 0, 0};
        send_request(v);
        v = '{0, 0, 0, 32'sh0003_0000, 0, 0, 32'sh0001_0000, 0, 0};
        send_request(v);
        v = '{0, 0, 0, 0, 0, 32'sh0001_0000, 0, 0, -32'sh0004_0000};
        send_request(v);
        v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
        send_request(v);
        v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_request(v);
        v = '{32'sh7fff_0000, 32'sh7fff_0000, 32'sh7fff_0000, 0, 0, 0, 1, 0, 0};
        send_request(v);
        v = '{-1, -1, -1, 1, 1, 1, -1, 1, -1};
        send_request(v);
        v = '{32'shffff_ffff, 0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh8000_0001,
              32'sh7fff_fffe, 32'sh1234_5678, 32'shedcb_a987, 1};
        send_request(v);

        // long result hold-off while requests keep coming, enough to back up the pipeline
        stall_long = 1'b1;
        repeat (N_PRESSURE) random_request();

        // pause until every row has arrived
        request.valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            random_request();
            if ($urandom_range(0, 2) != 0) idle_for(gap_len());
        end
        request.valid <= 1'b0;

        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("look_at_view_matrix_unit_tb passed");
        else
            $display("look_at_view_matrix_unit_tb failed");
        $finish;
    end
endmodule
